/* rtl/core/spq_pkg.sv */
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_POP,
        ST_FINISH
    } state_t;

endpackage

/* rtl/core/spq_if.sv */
interface spq_req_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] data_value;
    logic [PRIO_W-1:0]         prio;

    modport source (output valid, action, data_value, prio, input ready);
    modport sink (input valid, action, data_value, prio, output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         fill_count;

    modport source (output valid, out_value, status, fill_count, input ready);
    modport sink (input valid, out_value, status, fill_count, output ready);
endinterface

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue with QUEUE_DEPTH entries held in one memory in
// ascending priority order. Each request word on req is a push, a pop or a
// clear, and every request gives exactly one response word on rsp with the
// popped value, a status code and the entry count after the operation.
// Requests are taken one at a time; req.ready is high while the controller
// is idle. Clear, an unused action, a pop on an empty queue and a push to a
// full or empty queue answer in the cycle after acceptance if the output
// register is free, else from ST_FINISH. A pop reads the top slot through
// the memory read port and answers via ST_POP and ST_FINISH. A push walks
// down from the top slot, moving one entry up per cycle through the single
// read and write ports past each entry whose priority is greater or equal.
// The response sits in an output register, so the next request is
// accepted while a response waits; a stalled rsp holds the controller in
// its final state until the word is taken. Reset empties the queue and
// drops any pending response; the memory contents are not cleared.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    spq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    spq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

/* rtl/core/spq_mem.sv */
module spq_mem
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t store_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/spq_ctrl.sv */
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    spq_req_if.sink       req,
    spq_rsp_if.source     rsp,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  entry_t        rd_data,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output entry_t        wr_data
);

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             idx_reg, idx_next;
    entry_t                    push_reg, push_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    status_t                   res_status_reg, res_status_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t                   out_status_reg, out_status_next;
    logic [FILL_W-1:0]         out_fill_reg, out_fill_next;

    logic    out_free;
    logic    accept;
    logic    immediate;
    logic    shift_up;
    entry_t  new_entry;
    status_t imm_status;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign new_entry = '{value: req.data_value, prio: req.prio};
    assign shift_up  = (rd_data.prio >= push_reg.prio);

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_value  = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.fill_count = out_fill_reg;

    always_comb
    begin
        immediate  = 1'b1;
        imm_status = STAT_OK;
        unique case (req.action)
            ACT_PUSH:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    imm_status = STAT_FULL;
                end
                else if (count_reg != '0)
                begin
                    immediate = 1'b0;
                end
            end
            ACT_POP:
            begin
                if (count_reg == '0)
                begin
                    imm_status = STAT_EMPTY;
                end
                else
                begin
                    immediate = 1'b0;
                end
            end
            default:
            begin
                immediate = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (immediate)
                    begin
                        state_next = out_free ? ST_IDLE : ST_FINISH;
                    end
                    else if (req.action == ACT_POP)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (!shift_up)
                begin
                    state_next = ST_FINISH;
                end
                else if (idx_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:  state_next = ST_FINISH;
            ST_POP:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        push_next       = push_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        rd_en           = 1'b0;
        rd_addr         = AW'(count_reg - CW'(1));
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = push_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    push_next      = new_entry;
                    res_value_next = '0;
                    unique case (req.action)
                        ACT_PUSH:
                        begin
                            if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_data    = new_entry;
                                count_next = CW'(1);
                            end
                            else if (count_reg != CW'(DEPTH))
                            begin
                                rd_en      = 1'b1;
                                idx_next   = AW'(count_reg - CW'(1));
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    res_status_next = imm_status;
                    if (immediate && out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = imm_status;
                        out_fill_next   = FILL_W'(32'(count_next));
                    end
                end
            end
            ST_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                if (shift_up)
                begin
                    wr_data = rd_data;
                    if (idx_reg != '0)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wr_data = push_reg;
                end
            end
            ST_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = push_reg;
            end
            ST_POP:
            begin
                res_value_next = rd_data.value;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_fill_next   = FILL_W'(32'(count_reg));
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        push_reg       <= push_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
    end

endmodule

/* verif/sorted_priority_queue_checker.sv */
`timescale 1ns / 100ps

module sorted_priority_queue_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   fail_count,
    output int   pending_answers
);

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
        logic [FILL_W-1:0]         fill;
    } answer_t;

    entry_t  slots [QUEUE_DEPTH];
    int      held;
    answer_t expected_answers [$];

    initial
    begin
        fail_count      = 0;
        pending_answers = 0;
        held            = 0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t ns: %s is %0h, expected %0h", $time, field, got, want);
    endtask

    function automatic answer_t predict_answer(input logic [ACTION_W-1:0] act,
                                               input logic signed [VALUE_W-1:0] v,
                                               input logic [PRIO_W-1:0] p);
        answer_t ans;
        int      pos;
        ans.value  = '0;
        ans.status = STAT_OK;
        case (act)
            ACT_PUSH:
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    ans.status = STAT_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held && slots[pos].prio < p)
                    begin
                        pos++;
                    end
                    for (int k = held; k > pos; k--)
                    begin
                        slots[k] = slots[k-1];
                    end
                    slots[pos].value = v;
                    slots[pos].prio  = p;
                    held++;
                end
            end
            ACT_POP:
            begin
                if (held == 0)
                begin
                    ans.status = STAT_EMPTY;
                end
                else
                begin
                    held--;
                    ans.value = slots[held].value;
                end
            end
            ACT_CLEAR:
            begin
                held = 0;
            end
            default:
            begin
            end
        endcase
        ans.fill = held[FILL_W-1:0];
        return ans;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch("unexpected response word, out_value",
                                    rsp.out_value, '0);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp.out_value !== want.value)
                    begin
                        report_mismatch("out_value", rsp.out_value, want.value);
                    end
                    if (rsp.status !== want.status)
                    begin
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    end
                    if (rsp.fill_count !== want.fill)
                    begin
                        report_mismatch("fill_count", 32'(rsp.fill_count),
                                        32'(want.fill));
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_answers.push_back(predict_answer(req.action, req.data_value,
                                                          req.prio));
            end
            pending_answers = expected_answers.size();
        end
    end

endmodule

/* verif/sorted_priority_queue_tb.sv */
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_answers;
    int   send_idle_pct;
    int   stall_pct;
    int   hold_left;
    bit   hold_pending;

    spq_req_if req_bus ();
    spq_rsp_if rsp_bus ();

    sorted_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    sorted_priority_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_bus),
        .rsp            (rsp_bus),
        .fail_count     (fail_count),
        .pending_answers(pending_answers)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #8000000;
        $display("sorted_priority_queue verification failed");
        $finish;
    end

    // The receiver owns the long hold-off counter; the stimulus only requests it.
    initial
    begin
        rsp_bus.ready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic signed [VALUE_W-1:0] v,
                             input logic [PRIO_W-1:0] p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.action     <= act;
        req_bus.data_value <= v;
        req_bus.prio       <= p;
        do
        begin
            @(posedge clk);
        end
        while (!req_bus.ready);
        @(negedge clk);
    endtask

    task automatic drain_answers();
        req_bus.valid <= 1'b0;
        wait (pending_answers == 0);
        @(negedge clk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            return PRIO_W'($urandom_range(0, 7));
        end
        else if (sel < 8)
        begin
            return PRIO_W'($urandom_range(0, 65535));
        end
        else if (sel == 8)
        begin
            return '0;
        end
        return '1;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            return 32'h7fffffff;
        end
        else if (sel == 1)
        begin
            return 32'h80000000;
        end
        return $urandom;
    endfunction

    task automatic send_random_word(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
        begin
            send_word(ACT_PUSH, pick_value(), pick_prio());
        end
        else if (roll < 97)
        begin
            send_word(ACT_POP, pick_value(), pick_prio());
        end
        else if (roll < 99)
        begin
            send_word(ACT_CLEAR, pick_value(), pick_prio());
        end
        else
        begin
            send_word(ACT_UNUSED, pick_value(), pick_prio());
        end
    endtask

    initial
    begin
        int push_weights [4];
        int idle_modes [4][2];
        push_weights = '{30, 50, 70, 90};
        idle_modes   = '{'{0, 0}, '{62, 0}, '{0, 62}, '{18, 18}};

        rst_n              = 1'b0;
        hold_pending       = 1'b0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        req_bus.valid      = 1'b0;
        req_bus.action     = ACT_PUSH;
        req_bus.data_value = '0;
        req_bus.prio       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: empty pop, unused action, filling with tied and extreme
        // priorities, a push to a full queue, then clear and pop after clear.
        send_word(ACT_POP, 32'h12345678, 16'h00ff);
        send_word(ACT_UNUSED, 32'h7fffffff, 16'hffff);
        send_word(ACT_PUSH, 32'h7fffffff, 16'h0000);
        send_word(ACT_PUSH, 32'h80000000, 16'hffff);
        send_word(ACT_PUSH, 32'hffffffff, 16'h0005);
        send_word(ACT_PUSH, 32'h00000000, 16'h0005);
        send_word(ACT_PUSH, 32'h55555555, 16'h0005);
        send_word(ACT_PUSH, 32'haaaaaaaa, 16'hffff);
        send_word(ACT_PUSH, 32'h00000001, 16'h8000);
        send_word(ACT_PUSH, 32'h80000001, 16'h0000);
        send_word(ACT_PUSH, 32'h7ffffffe, 16'h7fff);
        send_word(ACT_PUSH, 32'h0000ffff, 16'h0001);
        send_word(ACT_PUSH, 32'hffff0000, 16'hfffe);
        send_word(ACT_PUSH, 32'h13572468, 16'h0005);
        send_word(ACT_PUSH, 32'h24681357, 16'h0004);
        send_word(ACT_PUSH, 32'hdeadbeef, 16'h0006);
        send_word(ACT_PUSH, 32'h0badcafe, 16'hffff);
        send_word(ACT_PUSH, 32'h11111111, 16'h0000);
        send_word(ACT_PUSH, 32'h80000000, 16'hffff);
        send_word(ACT_POP, 32'h0, 16'h0);
        send_word(ACT_UNUSED, 32'h0, 16'h0);
        send_word(ACT_CLEAR, 32'hffffffff, 16'hffff);
        send_word(ACT_POP, 32'h0, 16'h0);
        drain_answers();

        for (int mode = 0; mode < 4; mode++)
        begin
            send_idle_pct = idle_modes[mode][0];
            stall_pct     = idle_modes[mode][1];
            for (int chunk = 0; chunk < 5; chunk++)
            begin
                if (mode == 0 && chunk == 1)
                begin
                    hold_pending = 1'b1;
                    repeat (30)
                    begin
                        send_word(ACT_PUSH, pick_value(), pick_prio());
                    end
                end
                for (int n = 0; n < 50; n++)
                begin
                    send_random_word(push_weights[$urandom_range(0, 3)]);
                end
                if (chunk == 2)
                begin
                    drain_answers();
                end
            end
        end

        req_bus.valid <= 1'b0;
        wait (pending_answers == 0);
        stall_pct = 0;
        repeat (30) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("sorted_priority_queue verification clean");
        end
        else
        begin
            $display("sorted_priority_queue verification failed");
        end
        $finish;
    end

endmodule

/* sorted_priority_queue.f */
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_mem.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue.sv
verif/sorted_priority_queue_checker.sv
verif/sorted_priority_queue_tb.sv
